/* rtl/core/dtse_pkg.sv */
// Package for the date and time set editor: word types, key codes,
// field codes and calendar helpers. No dependencies.

package dtse_pkg;

  // Key event codes carried in the mode field
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_INC   = 2'd2;
  localparam logic [1:0] MODE_DEC   = 2'd3;

  // Field codes reported in editing_field
  localparam logic [2:0] CODE_IDLE   = 3'd0;
  localparam logic [2:0] CODE_YEAR   = 3'd1;
  localparam logic [2:0] CODE_MONTH  = 3'd2;
  localparam logic [2:0] CODE_DAY    = 3'd3;
  localparam logic [2:0] CODE_HOUR   = 3'd4;
  localparam logic [2:0] CODE_MINUTE = 3'd5;
  localparam logic [2:0] CODE_SECOND = 3'd6;

  // Field limits
  localparam logic [5:0] MONTH_MAX  = 6'd12;
  localparam logic [5:0] HOUR_MAX   = 6'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [5:0] LEAP_FEB   = 6'd29;
  localparam logic [15:0] LEAP_MASK = 16'h0003;

  // Field being edited, one-hot
  typedef enum logic [6:0] {
    F_IDLE   = 7'b0000001,
    F_YEAR   = 7'b0000010,
    F_MONTH  = 7'b0000100,
    F_DAY    = 7'b0001000,
    F_HOUR   = 7'b0010000,
    F_MINUTE = 7'b0100000,
    F_SECOND = 7'b1000000
  } field_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  editing_field;
    logic [15:0] shown_value;
    logic        commit;
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
  } out_word_t;

  // Days in the month; an invalid month counts as January
  function automatic logic [5:0] month_len(input logic [15:0] year, input logic [3:0] month);
    logic [5:0] len;
    begin
      case (month)
        4'd2:    len = ((year & LEAP_MASK) == 16'd0) ? LEAP_FEB : 6'd28;
        4'd4, 4'd6, 4'd9, 4'd11: len = 6'd30;
        default: len = 6'd31;
      endcase
      return len;
    end
  endfunction

  // Step a value up or down, wrapping between lo and hi
  function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic [5:0] lo,
                                           input logic [5:0] hi, input logic up);
    logic [5:0] r;
    begin
      if (up) begin
        r = (v >= hi) ? lo : v + 6'd1;
      end else begin
        r = (v <= lo) ? hi : v - 6'd1;
      end
      return r;
    end
  endfunction

  // Report code of a one-hot field
  function automatic logic [2:0] field_code(input field_t f);
    logic [2:0] c;
    begin
      case (f)
        F_YEAR:   c = CODE_YEAR;
        F_MONTH:  c = CODE_MONTH;
        F_DAY:    c = CODE_DAY;
        F_HOUR:   c = CODE_HOUR;
        F_MINUTE: c = CODE_MINUTE;
        F_SECOND: c = CODE_SECOND;
        default:  c = CODE_IDLE;
      endcase
      return c;
    end
  endfunction

endpackage

/* rtl/core/date_time_set_editor_top.sv */
// Date and time set editor: input register, edit logic and result register.
// Depends on dtse_pkg for word types, key codes and calendar helpers.
//
// Key-driven date and time editor. A start word loads the current date and
// time (a zero day or an out-of-range month, hour, minute or second becomes
// its lowest value) and begins editing the year; confirm steps through month,
// day, hour, minute and second, and increment/decrement wrap the current
// field within its range, while the year counts freely. Every accepted word
// returns exactly one result word with the field now edited and its value;
// confirming the second raises commit and carries all six values. A new word
// is accepted every cycle unless the output stalls; the edit state updates as
// a word passes the input register, so consecutive words chain without a gap.

module date_time_set_editor_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtse_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtse_pkg::out_word_t out_data
);

  // Input register
  logic               s1_valid;
  dtse_pkg::in_word_t s1_data;
  logic               advance;

  // Edit state
  dtse_pkg::field_t field, field_next;
  logic [15:0] year, year_next;
  logic [3:0]  month, month_next;
  logic [4:0]  day, day_next;
  logic [4:0]  hour, hour_next;
  logic [5:0]  minute, minute_next;
  logic [5:0]  second, second_next;
  logic        commit_next;
  logic [5:0]  len_cur;
  logic        up;
  dtse_pkg::out_word_t result;

  // Move the input word on when the result register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  assign len_cur = dtse_pkg::month_len(year, month);
  assign up      = (s1_data.mode == dtse_pkg::MODE_INC);

  // Next edit state for the word in the input register
  always_comb begin
    field_next  = field;
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    commit_next = 1'b0;
    if (s1_data.mode == dtse_pkg::MODE_START) begin
      // Load, replacing out-of-range values
      year_next   = s1_data.start_year;
      month_next  = (s1_data.start_month == 4'd0 || s1_data.start_month > 4'd12) ?
                    4'd1 : s1_data.start_month;
      day_next    = (s1_data.start_day == 5'd0) ? 5'd1 : s1_data.start_day;
      hour_next   = ({1'b0, s1_data.start_hour} > dtse_pkg::HOUR_MAX) ?
                    5'd0 : s1_data.start_hour;
      minute_next = (s1_data.start_minute > dtse_pkg::MINSEC_MAX) ?
                    6'd0 : s1_data.start_minute;
      second_next = (s1_data.start_second > dtse_pkg::MINSEC_MAX) ?
                    6'd0 : s1_data.start_second;
      field_next  = dtse_pkg::F_YEAR;
    end else if (s1_data.mode == dtse_pkg::MODE_NEXT) begin
      // Confirm: advance to the next field, commit after the second
      case (field)
        dtse_pkg::F_YEAR:   field_next = dtse_pkg::F_MONTH;
        dtse_pkg::F_MONTH: begin
          field_next = dtse_pkg::F_DAY;
          if ({1'b0, day} > len_cur) begin
            day_next = 5'd1;
          end
        end
        dtse_pkg::F_DAY:    field_next = dtse_pkg::F_HOUR;
        dtse_pkg::F_HOUR:   field_next = dtse_pkg::F_MINUTE;
        dtse_pkg::F_MINUTE: field_next = dtse_pkg::F_SECOND;
        dtse_pkg::F_SECOND: begin
          field_next  = dtse_pkg::F_IDLE;
          commit_next = 1'b1;
        end
        default:            field_next = dtse_pkg::F_IDLE;
      endcase
    end else begin
      // Increment or decrement the current field
      case (field)
        dtse_pkg::F_YEAR:   year_next = up ? year + 16'd1 : year - 16'd1;
        dtse_pkg::F_MONTH:  month_next = 4'(dtse_pkg::wrap_step({2'b0, month}, 6'd1,
                                              dtse_pkg::MONTH_MAX, up));
        dtse_pkg::F_DAY:    day_next = 5'(dtse_pkg::wrap_step({1'b0, day}, 6'd1,
                                            len_cur, up));
        dtse_pkg::F_HOUR:   hour_next = 5'(dtse_pkg::wrap_step({1'b0, hour}, 6'd0,
                                             dtse_pkg::HOUR_MAX, up));
        dtse_pkg::F_MINUTE: minute_next = dtse_pkg::wrap_step(minute, 6'd0,
                                            dtse_pkg::MINSEC_MAX, up);
        dtse_pkg::F_SECOND: second_next = dtse_pkg::wrap_step(second, 6'd0,
                                            dtse_pkg::MINSEC_MAX, up);
        default:            field_next = dtse_pkg::F_IDLE;
      endcase
    end
  end

  // Build the result word from the updated state
  always_comb begin
    result               = '0;
    result.editing_field = dtse_pkg::field_code(field_next);
    case (field_next)
      dtse_pkg::F_YEAR:   result.shown_value = year_next;
      dtse_pkg::F_MONTH:  result.shown_value = {12'd0, month_next};
      dtse_pkg::F_DAY:    result.shown_value = {11'd0, day_next};
      dtse_pkg::F_HOUR:   result.shown_value = {11'd0, hour_next};
      dtse_pkg::F_MINUTE: result.shown_value = {10'd0, minute_next};
      dtse_pkg::F_SECOND: result.shown_value = {10'd0, second_next};
      default:            result.shown_value = 16'd0;
    endcase
    if (commit_next) begin
      result.commit     = 1'b1;
      result.out_year   = year_next;
      result.out_month  = month_next;
      result.out_day    = day_next;
      result.out_hour   = hour_next;
      result.out_minute = minute_next;
      result.out_second = second_next;
    end
  end

  // Edit state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field  <= dtse_pkg::F_IDLE;
      year   <= 16'd0;
      month  <= 4'd1;
      day    <= 5'd1;
      hour   <= 5'd0;
      minute <= 6'd0;
      second <= 6'd0;
    end else if (s1_valid && advance) begin
      field  <= field_next;
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data <= result;
    end
  end

endmodule
